[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/bamu_pkg.sv]
// Package with constants, types and codes of the buddy allocator.
`default_nettype none
package bamu_pkg;
   localparam int ORDER_FLOOR = 12;
   localparam int ORDER_CEIL  = 34;
   localparam int STACK_DEPTH = 16;
   localparam int ALLOC_SLOTS = 64;

   localparam int ORDER_SPAN  = ORDER_CEIL - ORDER_FLOOR + 1;
   localparam int ORD_W       = $clog2(ORDER_SPAN + 1);
   localparam int ORDER_W     = $clog2(ORDER_CEIL + 2);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_W      = $clog2(ALLOC_SLOTS);
   localparam int BASE_W      = 34;
   localparam int SIZE_W      = 35;
   localparam int REQ_W       = 40;
   localparam int BLK_W       = BASE_W - ORDER_FLOOR;
   localparam int STK_WORDS   = ORDER_SPAN * STACK_DEPTH;
   localparam int STK_AW      = $clog2(STK_WORDS);
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 64;

   localparam logic [SIZE_W-1:0] POOL_RESET = 35'h4_0000_0000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NO_MEM   = 2'd2;
   localparam logic [1:0] ST_NOT_FND  = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [REQ_W-1:0]  request_size;
      logic [REQ_W-1:0]  request_align;
      logic [BASE_W-1:0] free_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [BASE_W-1:0] region_base;
      logic [SIZE_W-1:0] bytes_in_use;
   } rsp_type;

   typedef struct packed {
      logic [ORD_W-1:0] ord;
      logic [BLK_W-1:0] blk;
   } slot_type;
endpackage
`default_nettype wire

[hw/rtl/bamu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bamu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hw/rtl/buddy_allocator_no_coalesce_unit.sv]
// Top level of the buddy allocator without coalescing.
// Channel   | Direction | Handshake                | Payload
// request   | in        | start, busy              | req_data (bamu_pkg::req_type)
// result    | out       | rsp_valid (one cycle)    | rsp_data (bamu_pkg::rsp_type)
// registers | in/out    | psel, penable, pwrite    | paddr, pwdata, prdata, pready
// An allocate that reaches the split raises the order, scans the orders up to the found
// one, scans for a free slot, checks the stacks, pops and then splits. A free scans the
// table entry by entry, reading and then comparing each one. Early rejects answer in the
// cycle after acceptance without raising busy.
// After reset or a pool size write, initialization runs with busy high.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module buddy_allocator_no_coalesce_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire bamu_pkg::req_type             req_data,
   output logic                               rsp_valid,
   output bamu_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bamu_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [bamu_pkg::DATA_W-1:0]   pwdata,
   output logic      [bamu_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);
   import bamu_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_REQ   = 4'd2;
   localparam logic [3:0] S_FIND  = 4'd3;
   localparam logic [3:0] S_SLOT  = 4'd4;
   localparam logic [3:0] S_POP   = 4'd5;
   localparam logic [3:0] S_POPW  = 4'd6;
   localparam logic [3:0] S_SPLIT = 4'd7;
   localparam logic [3:0] S_FRD   = 4'd8;
   localparam logic [3:0] S_FCMP  = 4'd9;
   localparam logic [3:0] S_CHK   = 4'd10;

   logic [3:0]             state_ff, state_in;
   logic [SIZE_W-1:0]      pool_ff, pool_in;
   logic [ORD_W-1:0]       top_ff, top_in;
   logic [ORD_W-1:0]       ord_ff, ord_in;
   logic [ORD_W-1:0]       scan_ff, scan_in;
   logic [ORD_W-1:0]       found_ff, found_in;
   logic [SLOT_W-1:0]      k_ff, k_in;
   logic [BLK_W-1:0]       base_ff, base_in;
   logic [SIZE_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]       cnt_ff [ORDER_SPAN];
   logic [CNT_W-1:0]       cnt_in [ORDER_SPAN];
   logic [ALLOC_SLOTS-1:0] valid_ff, valid_in;
   req_type                req_ff, req_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   stk_we;
   logic [STK_AW-1:0]      stk_waddr, stk_raddr;
   logic [BLK_W-1:0]       stk_wdata, stk_rdata;
   logic                   tbl_we;
   slot_type               tbl_wdata, tbl_rdata;

   logic                   accept;
   logic                   cfg_wr;
   logic [ORDER_W-1:0]     cur_order;
   logic [REQ_W:0]         cur_pow;
   logic [ORDER_W-1:0]     next_top_order;
   logic [SIZE_W:0]        next_top_pow;
   logic [ORD_W-1:0]       lo_ord;
   logic [SIZE_W-1:0]      blk_bytes;

   assign accept = start && !busy;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign busy   = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign prdata = (paddr[ADDR_W-1] == 1'b0) ? DATA_W'(pool_ff) : '0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Shared shift-and-compare terms for the order walks.
   assign cur_order      = ORDER_W'(ord_ff) + ORDER_W'(ORDER_FLOOR);
   assign cur_pow        = (REQ_W+1)'(1) << cur_order;
   assign next_top_order = ORDER_W'(top_ff) + ORDER_W'(ORDER_FLOOR + 1);
   assign next_top_pow   = (SIZE_W+1)'(1) << next_top_order;
   assign lo_ord         = scan_ff - ORD_W'(1);

   // Free stacks: one LIFO per order, packed into one RAM.
   bamu_ram #(.WIDTH(BLK_W), .DEPTH(STK_WORDS)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // Allocation table: base and order of each live region.
   bamu_ram #(.WIDTH($bits(slot_type)), .DEPTH(ALLOC_SLOTS)) u_table_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (k_ff),
      .wdata (tbl_wdata),
      .raddr (k_ff),
      .rdata (tbl_rdata)
   );

   // Sequencer: next state of all control and payload registers.
   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      top_in       = top_ff;
      ord_in       = ord_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      stk_we       = 1'b0;
      stk_waddr    = '0;
      stk_wdata    = '0;
      stk_raddr    = '0;
      tbl_we       = 1'b0;
      tbl_wdata    = '{ord: ord_ff, blk: base_ff};
      blk_bytes    = SIZE_W'(1) << (ORDER_W'(tbl_rdata.ord) + ORDER_W'(ORDER_FLOOR));

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               ord_in = '0;
               k_in   = '0;
               rsp_in = '{status: ST_OK, region_base: '0, bytes_in_use: total_ff};
               if (req_data.operation == OP_ALLOC) begin
                  if (req_data.request_size == '0) begin
                     rsp_in.status = ST_INVALID;
                     rsp_valid_in  = 1'b1;
                  end else if (pool_ff == '0) begin
                     rsp_in.status = ST_NO_MEM;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = S_REQ;
                  end
               end else begin
                  if (req_data.free_handle == '0) begin
                     rsp_in.status = ST_INVALID;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = S_FRD;
                  end
               end
            end
         end
         // Raise the top order while the next power fits pool and range; then push block 0 there.
         S_INIT: begin
            if (pool_ff == '0) begin
               state_in = S_IDLE;
            end else if (top_ff < ORD_W'(ORDER_SPAN - 1) &&
                         next_top_pow <= (SIZE_W+1)'(pool_ff)) begin
               top_in = top_ff + ORD_W'(1);
            end else begin
               stk_we         = 1'b1;
               stk_waddr      = STK_AW'(top_ff * STACK_DEPTH);
               stk_wdata      = '0;
               cnt_in[top_ff] = CNT_W'(1);
               state_in       = S_IDLE;
            end
         end
         // Raise the order until it covers both size and alignment; reject once it passes the top order.
         S_REQ: begin
            if (ord_ff > top_ff) begin
               rsp_in.status = ST_INVALID;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (cur_pow < (REQ_W+1)'(req_ff.request_size) ||
                         cur_pow < (REQ_W+1)'(req_ff.request_align)) begin
               ord_in = ord_ff + ORD_W'(1);
            end else begin
               scan_in  = ord_ff;
               state_in = S_FIND;
            end
         end
         // Find the smallest order with a free block.
         S_FIND: begin
            if (cnt_ff[scan_ff] != '0) begin
               found_in = scan_ff;
               k_in     = '0;
               state_in = S_SLOT;
            end else if (scan_ff == ORD_W'(ORDER_SPAN - 1)) begin
               rsp_in.status = ST_NO_MEM;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               scan_in = scan_ff + ORD_W'(1);
            end
         end
         // Find the first unused allocation slot.
         S_SLOT: begin
            if (!valid_ff[k_ff]) begin
               scan_in  = ord_ff;
               state_in = S_CHK;
            end else if (k_ff == SLOT_W'(ALLOC_SLOTS - 1)) begin
               rsp_in.status = ST_NO_MEM;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               k_in = k_ff + SLOT_W'(1);
            end
         end
         // Every stack that the split pushes to must have room.
         S_CHK: begin
            if (scan_ff == found_ff) begin
               state_in = S_POP;
            end else if (cnt_ff[scan_ff] >= CNT_W'(STACK_DEPTH)) begin
               rsp_in.status = ST_NO_MEM;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               scan_in = scan_ff + ORD_W'(1);
            end
         end
         // Pop the newest block of the found order.
         S_POP: begin
            cnt_in[found_ff] = cnt_ff[found_ff] - CNT_W'(1);
            stk_raddr = STK_AW'(found_ff * STACK_DEPTH) +
                        STK_AW'(cnt_ff[found_ff] - CNT_W'(1));
            state_in  = S_POPW;
         end
         S_POPW: begin
            base_in  = stk_rdata;
            scan_in  = found_ff;
            state_in = S_SPLIT;
         end
         // Split one order per cycle, pushing the upper half.
         S_SPLIT: begin
            if (scan_ff == ord_ff) begin
               tbl_we          = 1'b1;
               valid_in[k_ff]  = 1'b1;
               total_in        = total_ff + (SIZE_W'(1) << cur_order);
               rsp_in.status   = ST_OK;
               rsp_in.region_base  = {base_ff, ORDER_FLOOR'(0)};
               rsp_in.bytes_in_use = total_in;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               stk_we         = 1'b1;
               stk_waddr      = STK_AW'(lo_ord * STACK_DEPTH) + STK_AW'(cnt_ff[lo_ord]);
               stk_wdata      = base_ff + (BLK_W'(1) << lo_ord);
               cnt_in[lo_ord] = cnt_ff[lo_ord] + CNT_W'(1);
               scan_in        = lo_ord;
            end
         end
         S_FRD: begin
            state_in = S_FCMP;
         end
         // Compare one table entry against the handle.
         S_FCMP: begin
            if (valid_ff[k_ff] && tbl_rdata.blk == req_ff.free_handle[BASE_W-1:ORDER_FLOOR] &&
                req_ff.free_handle[ORDER_FLOOR-1:0] == '0) begin
               if (cnt_ff[tbl_rdata.ord] >= CNT_W'(STACK_DEPTH)) begin
                  rsp_in.status = ST_NO_MEM;
               end else begin
                  stk_we    = 1'b1;
                  stk_waddr = STK_AW'(tbl_rdata.ord * STACK_DEPTH) +
                              STK_AW'(cnt_ff[tbl_rdata.ord]);
                  stk_wdata = req_ff.free_handle[BASE_W-1:ORDER_FLOOR];
                  cnt_in[tbl_rdata.ord] = cnt_ff[tbl_rdata.ord] + CNT_W'(1);
                  valid_in[k_ff] = 1'b0;
                  if (total_ff >= blk_bytes) begin
                     total_in = total_ff - blk_bytes;
                  end
                  rsp_in.status       = ST_OK;
                  rsp_in.bytes_in_use = total_in;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (k_ff == SLOT_W'(ALLOC_SLOTS - 1)) begin
               rsp_in.status = ST_NOT_FND;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               k_in     = k_ff + SLOT_W'(1);
               state_in = S_FRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A pool size write restarts the pool from scratch.
      if (cfg_wr && paddr[ADDR_W-1] == 1'b0) begin
         pool_in  = pwdata[SIZE_W-1:0];
         top_in   = '0;
         total_in = '0;
         valid_in = '0;
         for (int i = 0; i < ORDER_SPAN; i++) begin
            cnt_in[i] = '0;
         end
         state_in = S_INIT;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pool_ff      <= POOL_RESET;
         top_ff       <= '0;
         total_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ORDER_SPAN; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         top_ff       <= top_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ord_ff   <= ord_in;
      scan_ff  <= scan_in;
      found_ff <= found_in;
      k_ff     <= k_in;
      base_ff  <= base_in;
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
   end

   // A result word only follows an accepted request or work on one.
   `ASSERT_IMPLIES(a_rsp_after_busy, clock, reset, rsp_valid, $past(accept || busy))
   // An accepted request always makes the block busy or brings an answer.
   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid)
   // A successful allocate returns a block-aligned base.
   `ASSERT_IMPLIES(a_base_aligned, clock, reset, rsp_valid && rsp_data.status == ST_OK,
      rsp_data.region_base[ORDER_FLOOR-1:0] == '0)
endmodule
`default_nettype wire
